// File: hdl/cluster_member_table_centroid_macros.svh
// Assertion macros for the cluster member table.
`ifndef CLUSTER_MEMBER_TABLE_CENTROID_MACROS_SVH
`define CLUSTER_MEMBER_TABLE_CENTROID_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CLMT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cluster member table assertion failed");
// Next-cycle implication.
`define CLMT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cluster member table assertion failed");
`else
`define CLMT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CLMT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/clmt_pkg.sv
// Shared types and constants of the cluster member table.
`default_nettype none
package clmt_pkg;
   localparam int CLMT_MAX_POINTS   = 256;
   localparam int CLMT_MAX_FEATURES = 16;

   typedef enum logic [1:0] {
      KIND_APPEND    = 2'd0,
      KIND_REMOVE    = 2'd1,
      KIND_RECOMPUTE = 2'd2,
      KIND_COUNT     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_LABEL  = 1'b0,
      CSR_FCOUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LSCAN,
      ST_DISPATCH,
      ST_RM_SEARCH,
      ST_RM_SHIFT,
      ST_RC_SUM,
      ST_RC_DIV,
      ST_RC_EMIT
   } state_type;
endpackage
`default_nettype wire

// File: hdl/clmt_ram.sv
// Simple dual-port RAM with registered read data.
`default_nettype none
module clmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: hdl/clmt_divider.sv
// Bit-serial signed by unsigned divider, truncating toward zero.
`default_nettype none
module clmt_divider #(
   parameter int SW = 41,
   parameter int CW = 9
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [SW-1:0] dividend,
   input  wire logic [CW-1:0] divisor,
   output logic               done,
   output logic [31:0]        quotient
);
   localparam int NW = $clog2(SW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [CW:0]   rem_ff, rem_in;
   logic [CW:0]   shifted;
   logic [SW-1:0] signed_quo;

   // One quotient bit per cycle, restoring form on the magnitude.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff[CW-1:0], quo_ff[SW-1]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SW-1];
         quo_in  = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
         rem_in  = '0;
         cnt_in  = NW'(SW);
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = shifted - {1'b0, divisor};
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // Restore the sign of the quotient.
   assign signed_quo = neg_ff ? (~quo_ff + SW'(1)) : quo_ff;
   assign quotient   = signed_quo[31:0];
   assign done       = done_ff;
endmodule
`default_nettype wire

// File: hdl/cluster_member_table_centroid.sv
// Append and count pass through dispatch only; a label write adds a scan of all members
// before the next item. Remove: dispatch, an id search, then every later row shifted down
// one feature at a time. Recompute: dispatch, then per component a summing pass over all
// members, a bit-serial divide and the emit of its result.
// Reset (synchronous): member count, append position and correct count go to zero;
// the member memories are left undefined and get no clearing pass.
`default_nettype none
`include "cluster_member_table_centroid_macros.svh"
module cluster_member_table_centroid
   import clmt_pkg::*;
#(
   parameter int MAX_POINTS   = CLMT_MAX_POINTS,
   parameter int MAX_FEATURES = CLMT_MAX_FEATURES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_point_id,
   input  wire logic [8:0]  req_target_class,
   input  wire logic [31:0] req_feature_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_component_index,
   output logic [31:0]      rsp_centroid_value,
   output logic [8:0]       rsp_correct_count,
   output logic [8:0]       rsp_total_points,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_wdata
);
   localparam int RW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int FCW = $clog2(MAX_FEATURES + 1);
   localparam int SW  = 32 + CW;
   localparam int FDEPTH = 1 << (RW + FW);

   state_type     state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [FW-1:0] pos_ff, pos_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] correct_ff, correct_in;
   logic          dirty_ff, dirty_in;
   logic [8:0]    label_ff, label_in;
   logic [4:0]    fcount_ff, fcount_in;
   kind_type      kind_ff, kind_in;
   logic [15:0]   id_ff, id_in;
   logic [8:0]    cls_ff, cls_in;
   logic [31:0]   feat_ff, feat_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [FW-1:0] col_ff, col_in;
   logic          pend_ff, pend_in;
   logic [RW-1:0] prow_ff, prow_in;
   logic [FW-1:0] pcol_ff, pcol_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [3:0]    rsp_comp_ff, rsp_comp_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [FCW-1:0] fc;
   logic [CW-1:0]  limit;
   logic [CW-1:0]  idx_inc;
   logic           issue, scan_done, found, emit_last, slot_free, accept;
   logic           append_drop, append_commit;
   logic [RW-1:0]  rd_row;

   logic               fm_we, im_we;
   logic [RW+FW-1:0]   fm_waddr;
   logic [31:0]        fm_wdata, fm_rdata;
   logic [RW-1:0]      im_waddr;
   logic [15:0]        id_wdata, id_rdata;
   logic [8:0]         cls_wdata, cls_rdata;
   logic               div_start, div_done;
   logic [31:0]        div_quot;

   // Features in use after clamping.
   always_comb begin
      if (fcount_ff == 5'd0) begin
         fc = FCW'(1);
      end else if (int'(fcount_ff) > MAX_FEATURES) begin
         fc = FCW'(MAX_FEATURES);
      end else begin
         fc = FCW'(fcount_ff);
      end
   end

   // Shared scan conditions.
   assign limit     = (state_ff == ST_RM_SHIFT) ? lim_ff : total_ff;
   assign issue     = idx_ff < limit;
   assign scan_done = !issue && !pend_ff;
   assign found     = pend_ff && (id_rdata == id_ff);
   assign emit_last = (int'(col_ff) + 1) == int'(fc);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign idx_inc   = idx_ff + CW'(1);
   assign rd_row    = (state_ff == ST_RM_SHIFT) ? idx_inc[RW-1:0] : idx_ff[RW-1:0];
   assign append_drop   = (pos_ff == '0) ? (int'(total_ff) >= MAX_POINTS) : dropped_ff;
   assign append_commit = (int'(pos_ff) + 1) >= int'(fc);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = dirty_ff ? ST_LSCAN : ST_DISPATCH;
            end
         end
         ST_LSCAN: begin
            if (scan_done) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (kind_ff)
               KIND_REMOVE:    state_in = ST_RM_SEARCH;
               KIND_RECOMPUTE: state_in = (total_ff == '0) ? ST_RC_EMIT : ST_RC_SUM;
               default:        state_in = ST_IDLE;
            endcase
         end
         ST_RM_SEARCH: begin
            if (found) begin
               state_in = ST_RM_SHIFT;
            end else if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_RM_SHIFT: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_RC_SUM: begin
            if (scan_done) begin
               state_in = ST_RC_DIV;
            end
         end
         ST_RC_DIV: begin
            if (div_done) begin
               state_in = ST_RC_EMIT;
            end
         end
         ST_RC_EMIT: begin
            if (slot_free) begin
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = (total_ff == '0) ? ST_RC_EMIT : ST_RC_SUM;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      total_in      = total_ff;
      pos_in        = pos_ff;
      dropped_in    = dropped_ff;
      correct_in    = correct_ff;
      dirty_in      = dirty_ff;
      label_in      = label_ff;
      fcount_in     = fcount_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      cls_in        = cls_ff;
      feat_in       = feat_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      pend_in       = pend_ff;
      prow_in       = prow_ff;
      pcol_in       = pcol_ff;
      lim_in        = lim_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      fm_we         = 1'b0;
      fm_waddr      = {total_ff[RW-1:0], pos_ff};
      fm_wdata      = feat_ff;
      im_we         = 1'b0;
      im_waddr      = total_ff[RW-1:0];
      id_wdata      = id_ff;
      cls_wdata     = cls_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = kind_type'(req_kind);
               id_in      = req_point_id;
               cls_in     = req_target_class;
               feat_in    = req_feature_value;
               idx_in     = '0;
               pend_in    = 1'b0;
               if (dirty_ff) begin
                  correct_in = '0;
               end
            end
         end
         // Recount members whose class matches a newly written label.
         ST_LSCAN: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_inc;
            end
            if (pend_ff && (cls_rdata == label_ff)) begin
               correct_in = correct_ff + CW'(1);
            end
            if (scan_done) begin
               dirty_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            unique case (kind_ff)
               KIND_APPEND: begin
                  fm_we = !append_drop;
                  if (append_commit) begin
                     if (!append_drop) begin
                        im_we    = 1'b1;
                        total_in = total_ff + CW'(1);
                        if (cls_ff == label_ff) begin
                           correct_in = correct_ff + CW'(1);
                        end
                     end
                     pos_in     = '0;
                     dropped_in = 1'b0;
                  end else begin
                     pos_in     = pos_ff + FW'(1);
                     dropped_in = append_drop;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = append_drop ? STAT_FULL : STAT_OK;
                  rsp_comp_in   = '0;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
               end
               KIND_REMOVE: begin
                  idx_in  = '0;
                  pend_in = 1'b0;
               end
               KIND_RECOMPUTE: begin
                  idx_in  = '0;
                  pend_in = 1'b0;
                  col_in  = '0;
                  acc_in  = '0;
               end
               KIND_COUNT: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_comp_in   = '0;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
               end
               default: ;
            endcase
         end
         // Search ids in order; the first hit starts the shift.
         ST_RM_SEARCH: begin
            if (found) begin
               if (cls_rdata == label_ff) begin
                  correct_in = correct_ff - CW'(1);
               end
               idx_in  = idx_ff - CW'(1);
               col_in  = '0;
               pend_in = 1'b0;
               lim_in  = (int'(total_ff) < MAX_POINTS) ? total_ff : (total_ff - CW'(1));
            end else begin
               pend_in = issue;
               if (issue) begin
                  idx_in = idx_inc;
               end
               if (scan_done) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_comp_in   = '0;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         // Move each later row, partial point included, down by one.
         ST_RM_SHIFT: begin
            pend_in = issue;
            if (issue) begin
               prow_in = idx_ff[RW-1:0];
               pcol_in = col_ff;
               if (int'(col_ff) == MAX_FEATURES - 1) begin
                  col_in = '0;
                  idx_in = idx_inc;
               end else begin
                  col_in = col_ff + FW'(1);
               end
            end
            if (pend_ff) begin
               fm_we     = 1'b1;
               fm_waddr  = {prow_ff, pcol_ff};
               fm_wdata  = fm_rdata;
               im_we     = (pcol_ff == '0);
               im_waddr  = prow_ff;
               id_wdata  = id_rdata;
               cls_wdata = cls_rdata;
            end
            if (scan_done) begin
               total_in      = total_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_comp_in   = '0;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end
         // Accumulate one component over all members.
         ST_RC_SUM: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_inc;
            end
            if (pend_ff) begin
               acc_in = acc_ff + {{(SW-32){fm_rdata[31]}}, fm_rdata};
            end
            div_start = scan_done;
         end
         ST_RC_DIV: ;
         ST_RC_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (total_ff == '0) ? STAT_EMPTY : STAT_OK;
               rsp_comp_in   = 4'(col_ff);
               rsp_value_in  = (total_ff == '0) ? 32'd0 : div_quot;
               rsp_last_in   = emit_last;
               if (!emit_last) begin
                  col_in  = col_ff + FW'(1);
                  idx_in  = '0;
                  pend_in = 1'b0;
                  acc_in  = '0;
               end
            end
         end
         default: ;
      endcase

      // The user must write the registers only while the block is idle; the block does not enforce it.
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LABEL: begin
               label_in = csr_wdata;
               dirty_in = 1'b1;
            end
            CSR_FCOUNT: fcount_in = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         pos_ff       <= '0;
         dropped_ff   <= 1'b0;
         correct_ff   <= '0;
         dirty_ff     <= 1'b0;
         label_ff     <= 9'h1FF;
         fcount_ff    <= 5'(CLMT_MAX_FEATURES);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         dropped_ff   <= dropped_in;
         correct_ff   <= correct_in;
         dirty_ff     <= dirty_in;
         label_ff     <= label_in;
         fcount_ff    <= fcount_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      cls_ff        <= cls_in;
      feat_ff       <= feat_in;
      idx_ff        <= idx_in;
      col_ff        <= col_in;
      prow_ff       <= prow_in;
      pcol_ff       <= pcol_in;
      lim_ff        <= lim_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Member storage.
   clmt_ram #(.WIDTH(32), .DEPTH(FDEPTH)) u_feat_ram (
      .clock(clock), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
      .raddr({rd_row, col_ff}), .rdata(fm_rdata)
   );

   clmt_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_id_ram (
      .clock(clock), .we(im_we), .waddr(im_waddr), .wdata(id_wdata),
      .raddr(rd_row), .rdata(id_rdata)
   );

   clmt_ram #(.WIDTH(9), .DEPTH(MAX_POINTS)) u_cls_ram (
      .clock(clock), .we(im_we), .waddr(im_waddr), .wdata(cls_wdata),
      .raddr(rd_row), .rdata(cls_rdata)
   );

   // Mean of one component.
   clmt_divider #(.SW(SW), .CW(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(acc_ff),
      .divisor(total_ff), .done(div_done), .quotient(div_quot)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_component_index = rsp_comp_ff;
   assign rsp_centroid_value  = rsp_value_ff;
   assign rsp_correct_count   = 9'(correct_ff);
   assign rsp_total_points    = 9'(total_ff);
   assign rsp_last            = rsp_last_ff;

   `CLMT_ASSERT_IMPL(a_total_bound, clock, reset, 1'b1, int'(total_ff) <= MAX_POINTS)
   `CLMT_ASSERT_IMPL(a_correct_bound, clock, reset, 1'b1, correct_ff <= total_ff)
   `CLMT_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the cluster member table with centroid recompute.
`timescale 1ns / 1ps
module tb_top;
   import clmt_pkg::*;

   // One result of the block, as the monitor sees it.
   typedef struct packed {
      status_type  status;
      logic [3:0]  comp;
      logic [31:0] value;
      logic [8:0]  correct;
      logic [8:0]  total;
      logic        last;
   } centroid_result_type;

   // Keeps its own copy of the member table and the queue of results it expects.
   class centroid_scoreboard_type;
      logic [31:0] feats [CLMT_MAX_POINTS+1][CLMT_MAX_FEATURES];
      logic [15:0] ids [CLMT_MAX_POINTS+1];
      logic [8:0]  classes [CLMT_MAX_POINTS+1];
      int unsigned total;
      int unsigned append_pos;
      bit          dropped;
      logic [8:0]  label;
      logic [4:0]  fcount;
      centroid_result_type pending [$];
      int          errors;

      function new();
         total = 0;
         append_pos = 0;
         dropped = 0;
         label = 9'h1FF;
         fcount = 5'd16;
         errors = 0;
      endfunction

      // A count of zero acts as one; counts above the table width are clamped.
      function int unsigned active_features();
         if (fcount == 0) return 1;
         if (fcount > CLMT_MAX_FEATURES) return CLMT_MAX_FEATURES;
         return fcount;
      endfunction

      function logic [8:0] correct_members();
         logic [8:0] n;
         n = 0;
         for (int i = 0; i < total; i++)
            if (classes[i] == label) n++;
         return n;
      endfunction

      function void push(status_type st, int unsigned comp, logic [31:0] value, bit last);
         centroid_result_type r;
         r.status  = st;
         r.comp    = comp[3:0];
         r.value   = value;
         r.correct = correct_members();
         r.total   = total[8:0];
         r.last    = last;
         pending.insert(pending.size(), r);
      endfunction

      // Updates the table for one accepted request and queues its results.
      function void note_request(kind_type kind, logic [15:0] id, logic [8:0] cls,
                                 logic [31:0] feat);
         int unsigned fc;
         longint sum;
         longint mean;
         bit found;
         fc = active_features();
         case (kind)
            KIND_APPEND: begin
               if (append_pos == 0) dropped = (total >= CLMT_MAX_POINTS);
               if (!dropped) feats[total][append_pos % CLMT_MAX_FEATURES] = feat;
               if (append_pos + 1 >= fc) begin
                  if (!dropped) begin
                     ids[total] = id;
                     classes[total] = cls;
                     total++;
                  end
                  append_pos = 0;
                  push(dropped ? STAT_FULL : STAT_OK, 0, 0, 1);
                  dropped = 0;
               end else begin
                  append_pos = (append_pos + 1) % CLMT_MAX_FEATURES;
                  push(dropped ? STAT_FULL : STAT_OK, 0, 0, 1);
               end
            end
            KIND_REMOVE: begin
               found = 0;
               for (int i = 0; i < total && !found; i++) begin
                  if (ids[i] == id) begin
                     // The rows behind, the partial point included, move down one.
                     for (int k = i; k < total; k++) begin
                        feats[k] = feats[k+1];
                        ids[k] = ids[k+1];
                        classes[k] = classes[k+1];
                     end
                     total--;
                     found = 1;
                  end
               end
               push(found ? STAT_OK : STAT_NOT_FOUND, 0, 0, 1);
            end
            KIND_RECOMPUTE: begin
               for (int j = 0; j < fc; j++) begin
                  if (total == 0) begin
                     push(STAT_EMPTY, j, 0, j + 1 == fc);
                  end else begin
                     sum = 0;
                     for (int i = 0; i < total; i++)
                        sum += longint'($signed(feats[i][j]));
                     mean = sum / longint'(total);
                     push(STAT_OK, j, mean[31:0], j + 1 == fc);
                  end
               end
            end
            default: begin
               push(STAT_OK, 0, 0, 1);
            end
         endcase
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch on %s: got %0h, expected %0h", field, got, want);
         errors++;
      endtask

      task check_result(centroid_result_type got);
         centroid_result_type want;
         if (pending.size() == 0) begin
            $display("result with no request waiting for it");
            errors++;
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.comp !== want.comp) report_mismatch("component_index", got.comp, want.comp);
            if (got.value !== want.value) report_mismatch("centroid_value", got.value, want.value);
            if (got.correct !== want.correct)
               report_mismatch("correct_count", got.correct, want.correct);
            if (got.total !== want.total) report_mismatch("total_points", got.total, want.total);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [15:0] req_point_id;
   logic [8:0]  req_target_class;
   logic [31:0] req_feature_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_component_index;
   logic [31:0] rsp_centroid_value;
   logic [8:0]  rsp_correct_count;
   logic [8:0]  rsp_total_points;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [8:0]  csr_wdata;

   centroid_scoreboard_type members = new();
   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  hold_request;
   bit  hold_done;

   cluster_member_table_centroid DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_point_id(req_point_id), .req_target_class(req_target_class),
      .req_feature_value(req_feature_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_component_index(rsp_component_index), .rsp_centroid_value(rsp_centroid_value),
      .rsp_correct_count(rsp_correct_count), .rsp_total_points(rsp_total_points),
      .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_done = 1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Outputs are stable at the falling edge, so results are checked there.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         members.check_result({status_type'(rsp_status), rsp_component_index,
                               rsp_centroid_value, rsp_correct_count,
                               rsp_total_points, rsp_last});
   end

   // Offers one request and returns at the edge that accepts it.
   task send_request(kind_type kind, logic [15:0] id, logic [8:0] cls, logic [31:0] feat);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_point_id <= id;
      req_target_class <= cls;
      req_feature_value <= feat;
      do @(negedge clock); while (!req_ready);
      members.note_request(kind, id, cls, feat);
      @(posedge clock);
   endtask

   // Waits until every expected result has come back.
   task settle();
      req_valid <= 1'b0;
      while (members.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task csr_write(csr_index_type index, logic [8:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_LABEL) members.label = data;
      else members.fcount = data[4:0];
      @(posedge clock);
   endtask

   // Completes any partial point, then removes members from the back until empty.
   task empty_table();
      while (members.append_pos != 0)
         send_request(KIND_APPEND, 16'($urandom), 9'($urandom), $urandom);
      while (members.total != 0)
         send_request(KIND_REMOVE, members.ids[members.total-1], 9'($urandom), $urandom);
      settle();
   endtask

   function logic [8:0] pick_class();
      case ($urandom_range(0, 3))
         0: return members.label;
         1: return 9'h1FF;
         2: return 9'd255;
         default: return 9'($urandom);
      endcase
   endfunction

   task random_phase(int mode, logic [4:0] fc, logic [8:0] lbl, int items);
      int r;
      logic [15:0] id;
      req_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 76 : 0;
      rsp_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 13 : 0;
      csr_write(CSR_FCOUNT, fc);
      csr_write(CSR_LABEL, lbl);
      for (int n = 0; n < items; n++) begin
         if (mode == 2 && n == items / 3) hold_request = 1;
         r = $urandom_range(0, 99);
         if (members.total >= 48 && r < 60) r = 60;
         if (r < 60) begin
            id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            send_request(KIND_APPEND, id, pick_class(), $urandom);
         end else if (r < 74) begin
            if (members.total != 0 && $urandom_range(0, 9) < 7)
               id = members.ids[$urandom_range(0, members.total - 1)];
            else
               id = 16'($urandom_range(0, 15));
            send_request(KIND_REMOVE, id, 9'($urandom), $urandom);
         end else if (r < 87) begin
            send_request(KIND_RECOMPUTE, 16'($urandom), 9'($urandom), $urandom);
         end else begin
            send_request(KIND_COUNT, 16'($urandom), 9'($urandom), $urandom);
         end
      end
      empty_table();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_APPEND;
      req_point_id = 0;
      req_target_class = 0;
      req_feature_value = 0;
      csr_we = 1'b0;
      csr_index = CSR_LABEL;
      csr_wdata = 0;
      hold_request = 0;
      req_idle_pct = 13;
      rsp_idle_pct = 76;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cluster, extreme features, partial point, removal cases.
      csr_write(CSR_FCOUNT, 5'd2);
      csr_write(CSR_LABEL, 9'd5);
      send_request(KIND_COUNT, 0, 0, 0);
      send_request(KIND_RECOMPUTE, 0, 0, 0);
      send_request(KIND_REMOVE, 0, 0, 0);
      send_request(KIND_APPEND, 16'hFFFF, 9'd5, 32'h7FFFFFFF);
      send_request(KIND_APPEND, 16'hFFFF, 9'd5, 32'h80000000);
      send_request(KIND_APPEND, 16'h0000, 9'h1FF, 32'h7FFFFFFF);
      send_request(KIND_APPEND, 16'h0000, 9'h1FF, 32'h80000000);
      send_request(KIND_APPEND, 16'h1234, 9'd255, 32'hFFFFFFFF);
      send_request(KIND_APPEND, 16'h1234, 9'd255, 32'h00000001);
      send_request(KIND_APPEND, 16'h0007, 9'd3, 32'h00012345);
      send_request(KIND_RECOMPUTE, 0, 0, 0);
      send_request(KIND_COUNT, 0, 0, 0);
      send_request(KIND_REMOVE, 16'h0000, 0, 0);
      send_request(KIND_REMOVE, 16'h5555, 0, 0);
      send_request(KIND_APPEND, 16'h00AA, 9'd5, 32'hFFFF0000);
      send_request(KIND_RECOMPUTE, 0, 0, 0);
      send_request(KIND_COUNT, 0, 0, 0);
      settle();
      csr_write(CSR_LABEL, 9'h1FF);
      send_request(KIND_COUNT, 0, 0, 0);
      empty_table();

      // Random traffic under each idling pattern and several register settings.
      random_phase(0, 5'd4, 9'h1FF, 20);
      random_phase(1, 5'd1, 9'd255, 20);
      random_phase(2, 5'($urandom_range(2, 15)), 9'($urandom), 20);
      random_phase(0, 5'd0, 9'd0, 20);
      random_phase(2, 5'd31, 9'd5, 20);

      // Full table: a point started while full stays dropped after space frees.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      csr_write(CSR_FCOUNT, 5'd1);
      for (int i = 0; i < CLMT_MAX_POINTS; i++)
         send_request(KIND_APPEND, 16'(i), pick_class(), $urandom);
      settle();
      csr_write(CSR_FCOUNT, 5'd2);
      send_request(KIND_APPEND, 16'd999, 9'd5, $urandom);
      send_request(KIND_REMOVE, 16'd10, 0, 0);
      send_request(KIND_APPEND, 16'd999, 9'd5, $urandom);
      send_request(KIND_COUNT, 0, 0, 0);
      settle();
      csr_write(CSR_FCOUNT, 5'd1);
      send_request(KIND_RECOMPUTE, 0, 0, 0);
      send_request(KIND_APPEND, 16'd1000, 9'h1FF, 32'h7FFFFFFF);
      send_request(KIND_APPEND, 16'd1001, 9'd5, 32'h80000000);
      send_request(KIND_RECOMPUTE, 0, 0, 0);
      send_request(KIND_REMOVE, 16'd1001, 0, 0);

      settle();
      repeat (50) @(posedge clock);
      if (members.errors == 0 && members.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (members.pending.size() != 0)
            $display("%0d expected results never arrived", members.pending.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout waiting for the block");
      $display("== FAIL ==");
      $finish;
   end
endmodule
